/* hdl/mhr_pkg.sv */
package mhr_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int MAX_AXES      = 6;

    localparam int SLOT_W   = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int AX_IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int AXIS_W   = 3;
    localparam int WORD_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_AXES_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_MODE = 2'd1;

    // request kinds
    localparam logic ACT_PUT   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [AXIS_W-1:0] AXES_RESET = 3'd2;

    typedef logic [MAX_AXES-1:0][WORD_W-1:0] t_axes;

    typedef struct packed {
        logic put_we;
        logic q_start;
        logic rd_issue;
        logic load_pend;
        logic pend_to_out;
        logic empty_to_out;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic stop_hit;
        logic rem_zero;
        logic out_free;
    } t_status;

endpackage

/* hdl/mhr_ctrl.sv */
module mhr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_action,
    input  mhr_pkg::t_status i_status,
    output logic             o_stall,
    output mhr_pkg::t_cmd    o_cmd
);
    import mhr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_dv, n_dv;
    logic       r_pv, n_pv;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_dv    = r_dv;
        n_pv    = r_pv;
        o_cmd.out_last = (r_state == ST_FLUSH);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_state = ST_SCAN;
                        n_dv    = 1'b0;
                        n_pv    = 1'b0;
                    end else begin
                        o_cmd.put_we = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_dv) begin
                    if (i_status.stop_hit) begin
                        n_dv    = 1'b0;
                        n_state = ST_FLUSH;
                    end else if (!(i_status.match && r_pv && !i_status.out_free)) begin
                        if (i_status.match) begin
                            o_cmd.pend_to_out = r_pv;
                            o_cmd.load_pend   = 1'b1;
                            n_pv = 1'b1;
                        end
                        if (!i_status.rem_zero) begin
                            o_cmd.rd_issue = 1'b1;
                            n_dv = 1'b1;
                        end else begin
                            n_dv    = 1'b0;
                            n_state = ST_FLUSH;
                        end
                    end
                end else if (!i_status.rem_zero) begin
                    o_cmd.rd_issue = 1'b1;
                    n_dv = 1'b1;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    if (r_pv) begin
                        o_cmd.pend_to_out = 1'b1;
                    end else begin
                        o_cmd.empty_to_out = 1'b1;
                    end
                    n_pv    = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_dv    = 1'b0;
                n_pv    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dv    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_pv    <= n_pv;
        end
    end

    a_no_read_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |-> !i_status.rem_zero)
        else $error("read issued with no records left");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pend_to_out || o_cmd.empty_to_out) |-> i_status.out_free)
        else $error("output register overwritten while stalled");

    a_idle_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!o_cmd.rd_issue && !o_cmd.load_pend && !o_cmd.pend_to_out))
        else $error("scan activity while idle");

    a_query_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.q_start |=> (r_state == ST_SCAN) && !r_pv)
        else $error("query start did not enter scan");

endmodule

/* hdl/mhr_datapath.sv */
module mhr_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mhr_pkg::t_cmd                i_cmd,
    output mhr_pkg::t_status             o_status,
    input  logic                         i_cfg_we,
    input  logic [mhr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mhr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mhr_pkg::WORD_W-1:0]   i_event_time,
    input  logic [mhr_pkg::WORD_W-1:0]   i_window_start,
    input  logic [mhr_pkg::WORD_W-1:0]   i_window_stop,
    input  logic [mhr_pkg::AXIS_W-1:0]   i_first_axis,
    input  logic [mhr_pkg::AXIS_W-1:0]   i_axis_count,
    input  mhr_pkg::t_axes               i_values,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [mhr_pkg::WORD_W-1:0]   o_record_time,
    output mhr_pkg::t_axes               o_axes,
    output logic                         o_found,
    output logic                         o_last
);
    import mhr_pkg::*;

    logic [WORD_W-1:0] time_mem [HISTORY_DEPTH];
    t_axes             axis_mem [HISTORY_DEPTH];

    logic [AXIS_W-1:0]  r_axes_in_use;
    logic               r_rel;
    t_axes              r_last_vals, n_last_vals;
    t_axes              n_row;
    logic [SLOT_W-1:0]  r_wslot;
    logic [COUNT_W-1:0] r_count;

    logic [WORD_W-1:0]  r_start, r_stop;
    logic [SLOT_W-1:0]  r_idx, n_start_idx;
    logic [COUNT_W-1:0] r_rem;
    logic [WORD_W-1:0]  r_rd_time;
    t_axes              r_rd_axes;
    logic [WORD_W-1:0]  r_pend_time;
    t_axes              r_pend_axes;

    logic [AXIS_W-1:0]  w_n_axes, w_cnt;

    assign w_n_axes = (r_axes_in_use > AXIS_W'(MAX_AXES)) ? AXIS_W'(MAX_AXES) : r_axes_in_use;
    assign w_cnt    = (i_axis_count > AXIS_W'(MAX_AXES)) ? AXIS_W'(MAX_AXES) : i_axis_count;

    // record row built from held values and the supplied window of axes
    always_comb begin
        logic [AXIS_W-1:0] ax;
        logic [AXIS_W-1:0] off;
        for (int i = 0; i < MAX_AXES; i++) begin
            ax  = AXIS_W'(i);
            off = ax - i_first_axis;
            n_row[i]       = (ax < w_n_axes && !r_rel) ? r_last_vals[i] : '0;
            n_last_vals[i] = r_last_vals[i];
            if (ax >= i_first_axis && off < w_cnt && ax < w_n_axes) begin
                n_row[i]       = i_values[AX_IDX_W'(off)];
                n_last_vals[i] = i_values[AX_IDX_W'(off)];
            end
        end
    end

    assign n_start_idx = ({1'b0, r_wslot} >= r_count)
                       ? SLOT_W'({1'b0, r_wslot} - r_count)
                       : SLOT_W'({1'b0, r_wslot} + COUNT_W'(HISTORY_DEPTH) - r_count);

    assign o_status.match    = (r_rd_time >= r_start) && (r_rd_time < r_stop);
    assign o_status.stop_hit = (r_rd_time >= r_stop);
    assign o_status.rem_zero = (r_rem == '0);
    assign o_status.out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_we) begin
            time_mem[r_wslot] <= i_event_time;
            axis_mem[r_wslot] <= n_row;
        end
        if (i_cmd.rd_issue) begin
            r_rd_time <= time_mem[r_idx];
            r_rd_axes <= axis_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axes_in_use <= AXES_RESET;
            r_rel         <= 1'b0;
            r_last_vals   <= '0;
            r_wslot       <= '0;
            r_count       <= '0;
            r_rem         <= '0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AXES_IN_USE:   r_axes_in_use <= i_cfg_data[AXIS_W-1:0];
                    CFG_RELATIVE_MODE: r_rel         <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.put_we) begin
                r_last_vals <= n_last_vals;
                r_wslot <= (r_wslot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
                if (r_count != COUNT_W'(HISTORY_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.q_start) begin
                r_rem <= r_count;
            end else if (i_cmd.rd_issue) begin
                r_rem <= r_rem - 1'b1;
            end
            if (i_cmd.pend_to_out || i_cmd.empty_to_out) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_start <= i_window_start;
            r_stop  <= i_window_stop;
            r_idx   <= n_start_idx;
        end else if (i_cmd.rd_issue) begin
            r_idx <= (r_idx == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_idx + 1'b1;
        end
        if (i_cmd.load_pend) begin
            r_pend_time <= r_rd_time;
            r_pend_axes <= r_rd_axes;
        end
        if (i_cmd.pend_to_out) begin
            o_record_time <= r_pend_time;
            o_axes        <= r_pend_axes;
            o_found       <= 1'b1;
            o_last        <= i_cmd.out_last;
        end else if (i_cmd.empty_to_out) begin
            o_record_time <= '0;
            o_axes        <= '0;
            o_found       <= 1'b0;
            o_last        <= 1'b1;
        end
    end

endmodule

/* hdl/motion_history_ring_core.sv */
// motion history ring: keeps the latest timestamped six-axis pointer records
// input channel (i_valid / o_stall): a request with i_action low is a put that
//   writes one record and gives no result; with i_action high it is a time window
//   query
// output channel (o_valid / i_stall): a query returns every record, oldest
//   first, with start <= time < stop, stopping at the first time >= stop; the
//   final result carries o_last, an empty answer is one result with o_found low
// throughput: puts are taken back to back; a query holds o_stall until its final
//   result is loaded, and its scan reads one stored record per cycle through the
//   record memory's registered read port unless a stalled receiver holds it
// results: a held match is loaded into the output register when the scan reaches
//   the next match, the stop record or the end of the ring, an empty answer when
//   the scan ends; matches are held back
// reset: ring empty, held axis values zero, axes_in_use = 2, absolute mode;
//   the record memory itself is not cleared, a fill count bounds the scan
// receiver stall: the result stays in the output register, and the scan waits
//   once it holds a further result to pass on
// configuration writes (i_cfg_we) must be made only while no request is in flight;
//   the block itself does not enforce this
module motion_history_ring_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [mhr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mhr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_action,
    input  logic [31:0]                     i_event_time,
    input  logic [31:0]                     i_window_start,
    input  logic [31:0]                     i_window_stop,
    input  logic [2:0]                      i_first_axis,
    input  logic [2:0]                      i_axis_count,
    input  logic signed [31:0]              i_value_0,
    input  logic signed [31:0]              i_value_1,
    input  logic signed [31:0]              i_value_2,
    input  logic signed [31:0]              i_value_3,
    input  logic signed [31:0]              i_value_4,
    input  logic signed [31:0]              i_value_5,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [31:0]                     o_record_time,
    output logic signed [31:0]              o_axis_0,
    output logic signed [31:0]              o_axis_1,
    output logic signed [31:0]              o_axis_2,
    output logic signed [31:0]              o_axis_3,
    output logic signed [31:0]              o_axis_4,
    output logic signed [31:0]              o_axis_5,
    output logic                            o_found,
    output logic                            o_last
);
    import mhr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_axes   w_values;
    t_axes   w_axes;

    // supplied values, in order from first_axis
    assign w_values[0] = i_value_0;
    assign w_values[1] = i_value_1;
    assign w_values[2] = i_value_2;
    assign w_values[3] = i_value_3;
    assign w_values[4] = i_value_4;
    assign w_values[5] = i_value_5;

    // sequencer: idle, scan of the ring, final flush of the held match
    mhr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    // record memories, ring pointers, held match and output register
    mhr_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_event_time   (i_event_time),
        .i_window_start (i_window_start),
        .i_window_stop  (i_window_stop),
        .i_first_axis   (i_first_axis),
        .i_axis_count   (i_axis_count),
        .i_values       (w_values),
        .i_out_stall    (i_stall),
        .o_out_valid    (o_valid),
        .o_record_time  (o_record_time),
        .o_axes         (w_axes),
        .o_found        (o_found),
        .o_last         (o_last)
    );

    assign o_axis_0 = signed'(w_axes[0]);
    assign o_axis_1 = signed'(w_axes[1]);
    assign o_axis_2 = signed'(w_axes[2]);
    assign o_axis_3 = signed'(w_axes[3]);
    assign o_axis_4 = signed'(w_axes[4]);
    assign o_axis_5 = signed'(w_axes[5]);

endmodule

/* tb/mhr_window_checker.sv */
module mhr_window_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mhr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mhr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_req_valid,
    input  logic                            i_req_stall,
    input  logic                            i_action,
    input  logic [mhr_pkg::WORD_W-1:0]      i_event_time,
    input  logic [mhr_pkg::WORD_W-1:0]      i_window_start,
    input  logic [mhr_pkg::WORD_W-1:0]      i_window_stop,
    input  logic [mhr_pkg::AXIS_W-1:0]      i_first_axis,
    input  logic [mhr_pkg::AXIS_W-1:0]      i_axis_count,
    input  mhr_pkg::t_axes                  i_values,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic [mhr_pkg::WORD_W-1:0]      i_record_time,
    input  mhr_pkg::t_axes                  i_axes,
    input  logic                            i_found,
    input  logic                            i_last,
    output int                              o_mismatches,
    output int                              o_results_waiting,
    output int                              o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import mhr_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] stamp;
        t_axes             axes;
        logic              found;
        logic              last;
    } t_window_hit;

    // shadow copy of the ring
    logic [WORD_W-1:0] stamp_mem [HISTORY_DEPTH];
    t_axes             axes_mem  [HISTORY_DEPTH];
    t_axes             held_axes;
    int unsigned       next_slot;
    int unsigned       filled;
    logic [AXIS_W-1:0] axes_cfg;
    logic              relative_cfg;

    t_window_hit       window_results_q[$];
    int                mismatch_cnt;
    int                results_cnt;

    task automatic record_motion(input logic [WORD_W-1:0] stamp,
                                 input logic [AXIS_W-1:0] first,
                                 input logic [AXIS_W-1:0] count,
                                 input t_axes vals);
        int live_axes;
        int supplied;
        int ax;
        live_axes = (axes_cfg > MAX_AXES) ? MAX_AXES : int'(axes_cfg);
        supplied  = (count > MAX_AXES) ? MAX_AXES : int'(count);
        stamp_mem[next_slot] = stamp;
        // missing axes hold in absolute mode, zero in relative mode
        for (int a = 0; a < MAX_AXES; a++)
            axes_mem[next_slot][a] = (a < live_axes && !relative_cfg) ? held_axes[a] : '0;
        for (int k = 0; k < supplied; k++) begin
            ax = int'(first) + k;
            if (ax < live_axes) begin
                axes_mem[next_slot][ax] = vals[k];
                held_axes[ax] = vals[k];
            end
        end
        next_slot = (next_slot + 1) % HISTORY_DEPTH;
        if (filled < HISTORY_DEPTH)
            filled++;
    endtask

    task automatic answer_window(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        int unsigned slot;
        t_window_hit pend;
        logic        have_pend;
        slot = (next_slot + HISTORY_DEPTH - filled) % HISTORY_DEPTH;
        pend = '0;
        have_pend = 1'b0;
        for (int n = 0; n < filled; n++) begin
            if (stamp_mem[slot] >= hi)
                break;
            if (stamp_mem[slot] >= lo) begin
                if (have_pend)
                    window_results_q.push_back(pend);
                pend.stamp = stamp_mem[slot];
                pend.axes  = axes_mem[slot];
                pend.found = 1'b1;
                pend.last  = 1'b0;
                have_pend  = 1'b1;
            end
            slot = (slot + 1) % HISTORY_DEPTH;
        end
        // held-back match closes the answer; all zero when nothing matched
        pend.last = 1'b1;
        window_results_q.push_back(pend);
    endtask

    task automatic report(input string field, input logic [WORD_W-1:0] want_v,
                          input logic [WORD_W-1:0] got_v);
        mismatch_cnt++;
        $display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
    endtask

    task automatic check_result();
        t_window_hit want;
        results_cnt++;
        if (window_results_q.size() == 0) begin
            mismatch_cnt++;
            $display("%0t: unexpected result time %h found %b last %b",
                     $time, i_record_time, i_found, i_last);
        end else begin
            want = window_results_q.pop_front();
            if (i_record_time !== want.stamp)
                report("record_time", want.stamp, i_record_time);
            for (int a = 0; a < MAX_AXES; a++)
                if (i_axes[a] !== want.axes[a])
                    report($sformatf("axis_%0d", a), want.axes[a], i_axes[a]);
            if (i_found !== want.found)
                report("found", WORD_W'(want.found), WORD_W'(i_found));
            if (i_last !== want.last)
                report("last", WORD_W'(want.last), WORD_W'(i_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            next_slot    = 0;
            filled       = 0;
            held_axes    = '0;
            axes_cfg     = AXES_RESET;
            relative_cfg = 1'b0;
            window_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_AXES_IN_USE:   axes_cfg = i_cfg_data;
                    CFG_RELATIVE_MODE: relative_cfg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall)
                check_result();
            if (i_req_valid && !i_req_stall) begin
                if (i_action == ACT_QUERY)
                    answer_window(i_window_start, i_window_stop);
                else
                    record_motion(i_event_time, i_first_axis, i_axis_count, i_values);
            end
        end
        o_results_waiting <= window_results_q.size();
        o_mismatches      <= mismatch_cnt;
        o_results_seen    <= results_cnt;
    end

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mhr_pkg::*;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    // idle cycles between the last result and a register write
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_ITEMS   = 62;

    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   i_action;
    logic [WORD_W-1:0]      i_event_time;
    logic [WORD_W-1:0]      i_window_start;
    logic [WORD_W-1:0]      i_window_stop;
    logic [AXIS_W-1:0]      i_first_axis;
    logic [AXIS_W-1:0]      i_axis_count;
    t_axes                  i_values;
    logic                   i_stall;

    wire                            o_stall;
    wire                            o_valid;
    wire [WORD_W-1:0]               o_record_time;
    wire [MAX_AXES-1:0][WORD_W-1:0] o_axes;
    wire                            o_found;
    wire                            o_last;

    int   mismatches;
    int   results_waiting;
    int   results_seen;
    int   n_puts;
    int   n_queries;
    int   burst_left;
    logic hold_armed;

    motion_history_ring_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_event_time   (i_event_time),
        .i_window_start (i_window_start),
        .i_window_stop  (i_window_stop),
        .i_first_axis   (i_first_axis),
        .i_axis_count   (i_axis_count),
        .i_value_0      (i_values[0]),
        .i_value_1      (i_values[1]),
        .i_value_2      (i_values[2]),
        .i_value_3      (i_values[3]),
        .i_value_4      (i_values[4]),
        .i_value_5      (i_values[5]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_record_time  (o_record_time),
        .o_axis_0       (o_axes[0]),
        .o_axis_1       (o_axes[1]),
        .o_axis_2       (o_axes[2]),
        .o_axis_3       (o_axes[3]),
        .o_axis_4       (o_axes[4]),
        .o_axis_5       (o_axes[5]),
        .o_found        (o_found),
        .o_last         (o_last)
    );

    // watches both channels and the register port, predicts and compares
    mhr_window_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_valid       (i_valid),
        .i_req_stall       (o_stall),
        .i_action          (i_action),
        .i_event_time      (i_event_time),
        .i_window_start    (i_window_start),
        .i_window_stop     (i_window_stop),
        .i_first_axis      (i_first_axis),
        .i_axis_count      (i_axis_count),
        .i_values          (i_values),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_record_time     (o_record_time),
        .i_axes            (o_axes),
        .i_found           (o_found),
        .i_last            (o_last),
        .o_mismatches      (mismatches),
        .o_results_waiting (results_waiting),
        .o_results_seen    (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_axes random_axes();
        t_axes r;
        for (int a = 0; a < MAX_AXES; a++)
            r[a] = $urandom;
        return r;
    endfunction

    // present one request and hold it until the ring takes it; the sender
    // works in bursts, and a random gap may drop valid between bursts
    task automatic offer(input logic act, input logic [WORD_W-1:0] stamp,
                         input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                         input logic [AXIS_W-1:0] first, input logic [AXIS_W-1:0] count,
                         input t_axes vals);
        int gap;
        i_valid        <= 1'b1;
        i_action       <= act;
        i_event_time   <= stamp;
        i_window_start <= lo;
        i_window_stop  <= hi;
        i_first_axis   <= first;
        i_axis_count   <= count;
        i_values       <= vals;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (act == ACT_QUERY)
            n_queries++;
        else
            n_puts++;
        burst_left--;
        if (burst_left <= 0) begin
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // unused query fields of a put carry random noise
    task automatic put_motion(input logic [WORD_W-1:0] stamp, input logic [AXIS_W-1:0] first,
                              input logic [AXIS_W-1:0] count, input t_axes vals);
        offer(ACT_PUT, stamp, $urandom, $urandom, first, count, vals);
    endtask

    // unused put fields of a query carry random noise
    task automatic ask_window(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        offer(ACT_QUERY, $urandom, lo, hi, AXIS_W'($urandom_range(0, 7)),
              AXIS_W'($urandom_range(0, 7)), random_axes());
    endtask

    // stop sending, wait for every outstanding result, then idle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_waiting != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [AXIS_W-1:0] axes, input logic rel);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_AXES_IN_USE;
        i_cfg_data  <= axes;
        @(posedge i_clk);
        i_cfg_index <= CFG_RELATIVE_MODE;
        i_cfg_data  <= CFG_DATA_W'(rel);
        @(posedge i_clk);
        // a write past the last register must leave both alone
        i_cfg_index <= ($urandom_range(0, 1) == 0) ? CFG_SPARE_A : CFG_SPARE_B;
        i_cfg_data  <= CFG_DATA_W'($urandom_range(0, 7));
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: stall patterns change every so often, plus one long
    // hold-off so that queued results back up into the request channel
    initial begin : result_side
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       tick;
        logic     hold_done;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        hold_done = 1'b0;
        i_stall  <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
                    default:  i_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        t_axes             extreme_vals;
        logic [WORD_W-1:0] now_ms;
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [AXIS_W-1:0] first;
        logic [AXIS_W-1:0] count;
        int                pick;

        // every input known from time zero
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_AXES_IN_USE;
        i_cfg_data     <= '0;
        i_valid        <= 1'b0;
        i_action       <= ACT_PUT;
        i_event_time   <= '0;
        i_window_start <= '0;
        i_window_stop  <= '0;
        i_first_axis   <= '0;
        i_axis_count   <= '0;
        i_values       <= '0;
        hold_armed     = 1'b0;
        n_puts         = 0;
        n_queries      = 0;
        burst_left     = 1;
        extreme_vals   = {32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, run on the reset settings (two axes, absolute)
        ask_window(32'h0, 32'hFFFF_FFFF);                 // query on an empty ring
        put_motion(32'd0, 3'd0, 3'd2, extreme_vals);
        put_motion(32'd10, 3'd1, 3'd1, random_axes());    // axis 0 keeps its held value
        put_motion(32'd20, 3'd0, 3'd0, random_axes());    // nothing supplied
        put_motion(32'd30, 3'd1, 3'd3, random_axes());    // upper axes outside the device
        put_motion(32'd40, 3'd0, 3'd7, ~extreme_vals);    // count past the axis limit
        put_motion(32'd50, 3'd7, 3'd6, random_axes());    // first axis past the device
        ask_window(32'h0, 32'hFFFF_FFFF);
        ask_window(32'd15, 32'd25);
        ask_window(32'd100, 32'd200);                     // window above every record
        ask_window(32'd0, 32'd0);                         // oldest record ends the scan
        ask_window(32'd30, 32'd30);                       // zero-width window
        ask_window(32'd40, 32'd10);                       // start above stop
        put_motion(32'hFFFF_FFFF, 3'd0, 3'd6, random_axes());
        put_motion(32'd5, 3'd0, 3'd1, random_axes());     // older stamp after the newest
        ask_window(32'h0, 32'hFFFF_FFFF);                 // top stamp stops the scan
        ask_window(32'd0, 32'd11);
        ask_window(32'd5, 32'd6);                         // late record hidden behind stop

        now_ms = $urandom_range(1000, 32'h7FFF_FFFF);
        for (int p = 0; p < NUM_PHASES; p++) begin
            // registers only change with nothing in flight
            drain();
            case (p)
                0:       write_regs(3'd6, 1'b0);   // widest device, absolute
                1:       write_regs(3'd1, 1'b1);   // single axis, relative
                2:       write_regs(3'd4, 1'b0);
                3:       write_regs(3'd7, 1'b1);   // saturates to the axis limit
                default: write_regs(3'd0, 1'b0);   // device with no axes
            endcase
            // long receiver hold-off while requests keep coming
            if (p == 0)
                hold_armed = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    // mostly rising stamps, a few out of order
                    if ($urandom_range(0, 19) == 0)
                        stamp = ($urandom_range(0, 1) == 0) ? now_ms - $urandom_range(0, 5000)
                                                            : $urandom;
                    else begin
                        now_ms = now_ms + $urandom_range(0, 40);
                        stamp  = now_ms;
                    end
                    first = ($urandom_range(0, 7) == 0) ? AXIS_W'($urandom_range(6, 7))
                                                        : AXIS_W'($urandom_range(0, 5));
                    count = ($urandom_range(0, 7) == 0) ? 3'd7
                                                        : AXIS_W'($urandom_range(0, 6));
                    put_motion(stamp, first, count, random_axes());
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        // window over recent history
                        lo = now_ms - $urandom_range(0, 1200);
                        hi = lo + $urandom_range(1, 1200);
                    end else if (pick < 7) begin
                        lo = 32'h0;
                        hi = 32'hFFFF_FFFF;
                    end else if (pick == 7) begin
                        lo = $urandom;
                        hi = $urandom;
                    end else if (pick == 8) begin
                        lo = $urandom;
                        hi = lo;
                    end else begin
                        hi = now_ms - $urandom_range(0, 600);
                        lo = hi + $urandom_range(1, 600);
                    end
                    ask_window(lo, hi);
                end
            end
        end

        drain();
        $display("covered %0d puts and %0d window queries over %0d register settings",
                 n_puts, n_queries, NUM_PHASES + 1);
        $display("%0d query results compared, one long receiver hold-off included",
                 results_seen);
        if (mismatches == 0 && results_waiting == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("timeout with %0d results still expected", results_waiting);
        $display("tb_top failed");
        $finish;
    end

endmodule
